/* hw/rtl/imu_binary_frame_parser_macros.svh */
// Assertion macros used by the checker file.
`ifndef IMU_BINARY_FRAME_PARSER_MACROS_SVH
`define IMU_BINARY_FRAME_PARSER_MACROS_SVH

// Implication checked while out of reset.
`define IBFP_ASSERT_RUN(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked on every edge, reset included.
`define IBFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked while out of reset.
`define IBFP_ASSERT_RUN_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/ibfp_pkg.sv */
package ibfp_pkg;

  localparam int unsigned WIN_LEN = 10;
  localparam int unsigned AXIS_BYTES = 6;

  localparam logic [3:0] WIN_FULL   = 4'd10;
  localparam logic [7:0] START_BYTE = 8'd85;
  localparam logic [7:0] KIND_ACCEL = 8'h51;
  localparam logic [7:0] KIND_GYRO  = 8'h52;
  localparam logic [7:0] KIND_ANGLE = 8'h53;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [1:0]                   kind;
    logic [AXIS_BYTES-1:0][7:0]   bytes;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* hw/rtl/ibfp_front.sv */
module ibfp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic [7:0]          in_data_byte,
  input  logic                in_end_of_burst,
  input  ibfp_pkg::q_stat_t   q_stat,
  output logic                in_full,
  output logic                q_push,
  output ibfp_pkg::frame_rec_t q_rec
);
  import ibfp_pkg::*;

  byte_t       win_r   [WIN_LEN];
  byte_t       win_nxt [WIN_LEN];
  logic [3:0]  fill_r, fill_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        accept;
  logic        kind_ok;
  logic        match;
  logic [7:0]  kind_diff;

  assign in_full = q_stat.full;
  assign accept  = in_push && !q_stat.full;

  always_comb begin
    kind_ok = 1'b0;
    case (win_r[1]) inside
      KIND_ACCEL, KIND_GYRO, KIND_ANGLE: kind_ok = 1'b1;
      default:                           kind_ok = 1'b0;
    endcase
  end

  assign match = (fill_r == WIN_FULL) && (win_r[0] == START_BYTE) &&
                 (sum_r == in_data_byte) && kind_ok;

  assign kind_diff = win_r[1] - KIND_ACCEL;
  assign q_push    = accept && match;

  always_comb begin
    q_rec.kind = kind_diff[1:0];
    for (int i = 0; i < AXIS_BYTES; i++) begin
      q_rec.bytes[i] = win_r[i+2];
    end
  end

  // shift newest in at the top; zeros from a clear leave the sum unchanged
  always_comb begin
    for (int i = 0; i < WIN_LEN; i++) begin
      win_nxt[i] = win_r[i];
    end
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    if (accept) begin
      if (in_end_of_burst) begin
        for (int i = 0; i < WIN_LEN; i++) begin
          win_nxt[i] = '0;
        end
        fill_nxt = '0;
        sum_nxt  = '0;
      end else begin
        for (int i = 0; i < WIN_LEN - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[WIN_LEN-1] = in_data_byte;
        sum_nxt            = sum_r + in_data_byte - win_r[0];
        if (fill_r != WIN_FULL) begin
          fill_nxt = fill_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        win_r[i] <= '0;
      end
      fill_r <= '0;
      sum_r  <= '0;
    end else begin
      for (int i = 0; i < WIN_LEN; i++) begin
        win_r[i] <= win_nxt[i];
      end
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
    end
  end

endmodule

/* hw/rtl/ibfp_queue.sv */
module ibfp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ibfp_pkg::frame_rec_t wr_rec,
  input  logic                 pop,
  output ibfp_pkg::frame_rec_t rd_rec,
  output ibfp_pkg::q_stat_t    stat
);
  import ibfp_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  frame_rec_t    mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_rec     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* hw/rtl/ibfp_back.sv */
module ibfp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ibfp_pkg::q_stat_t    q_stat,
  input  ibfp_pkg::frame_rec_t q_rec,
  output logic                 q_pop,
  input  logic                 out_pop,
  output logic                 out_empty,
  output logic [1:0]           out_frame_kind,
  output logic signed [15:0]   out_axis_x,
  output logic signed [15:0]   out_axis_y,
  output logic signed [15:0]   out_axis_z
);
  import ibfp_pkg::*;

  logic                valid_r, valid_nxt;
  logic                load;
  logic [1:0]          kind_r;
  logic signed [15:0]  x_r, y_r, z_r;

  assign load      = !q_stat.empty && (!valid_r || out_pop);
  assign q_pop     = load;
  assign valid_nxt = load ? 1'b1 : (out_pop ? 1'b0 : valid_r);

  assign out_empty      = !valid_r;
  assign out_frame_kind = kind_r;
  assign out_axis_x     = x_r;
  assign out_axis_y     = y_r;
  assign out_axis_z     = z_r;

  // assemble little-endian axis words
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= q_rec.kind;
      x_r    <= signed'({q_rec.bytes[1], q_rec.bytes[0]});
      y_r    <= signed'({q_rec.bytes[3], q_rec.bytes[2]});
      z_r    <= signed'({q_rec.bytes[5], q_rec.bytes[4]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

/* hw/rtl/imu_binary_frame_parser.sv */
// A result goes through the result queue and the output register to the out_ ports.
// Throughput: one byte per cycle in while in_full is low, one result per cycle out while
// out_pop is held; in_full is high when the queue (QUEUE_DEPTH entries) is full.
// Reset: synchronous, active low; clears the byte window, its fill count and running sum,
// and empties the queue and output register. No clearing pass is needed.
module imu_binary_frame_parser #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_end_of_burst,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [1:0]         out_frame_kind,
  output logic signed [15:0] out_axis_x,
  output logic signed [15:0] out_axis_y,
  output logic signed [15:0] out_axis_z
);
  import ibfp_pkg::*;

  q_stat_t    q_stat;
  frame_rec_t wr_rec;
  frame_rec_t rd_rec;
  logic       q_push;
  logic       q_pop;

  ibfp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_data_byte    (in_data_byte),
    .in_end_of_burst (in_end_of_burst),
    .q_stat          (q_stat),
    .in_full         (in_full),
    .q_push          (q_push),
    .q_rec           (wr_rec)
  );

  ibfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_rec (wr_rec),
    .pop    (q_pop),
    .rd_rec (rd_rec),
    .stat   (q_stat)
  );

  ibfp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_rec          (rd_rec),
    .q_pop          (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_frame_kind (out_frame_kind),
    .out_axis_x     (out_axis_x),
    .out_axis_y     (out_axis_y),
    .out_axis_z     (out_axis_z)
  );

endmodule

/* hw/rtl/ibfp_checker.sv */
`include "imu_binary_frame_parser_macros.svh"

module ibfp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input logic [1:0]         out_frame_kind,
  input logic signed [15:0] out_axis_x,
  input logic signed [15:0] out_axis_y,
  input logic signed [15:0] out_axis_z
);

  logic [49:0] out_word;

  assign out_word = {out_frame_kind, out_axis_x, out_axis_y, out_axis_z};

  // hold a stalled result
  `IBFP_ASSERT_RUN_NEXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_word))

  `IBFP_ASSERT_RUN(a_kind_legal, !out_empty, out_frame_kind != 2'd3)

  `IBFP_ASSERT_NEXT(a_reset_idle, !rst_n, out_empty && !in_full)

endmodule

bind imu_binary_frame_parser ibfp_checker u_ibfp_checker (.*);
